>>> design/k_nearest_stable_selection_core_assert.svh
// Assertion macros included by the core design file.
`ifndef K_NEAREST_STABLE_SELECTION_CORE_ASSERT_SVH
`define K_NEAREST_STABLE_SELECTION_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define KNSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define KNSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define KNSS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define KNSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> design/knss_pkg.sv
package knss_pkg;

  localparam int DIST_W = 64;
  localparam int IDX_W  = 20;
  localparam int RANK_W = 5;
  localparam int CNT_W  = 6;
  // wide enough for any effective k up to the largest chain length
  localparam int KEFF_W = 7;

  localparam logic [CNT_W-1:0] COUNT_RESET = 6'd4;

  // register index codes (byte address / 4)
  localparam int  REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_NEIGHBOUR_COUNT = 1'b0;

  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  idx;
  } entry_t;

  typedef struct packed {
    logic insert;  // place the candidate, move the tail right
    logic shift;   // move every entry one cell toward the head
  } cell_ctrl_t;

endpackage

>>> design/knss_cand_if.sv
interface knss_cand_if;
  import knss_pkg::*;

  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [IDX_W-1:0]  row_index;
  logic              last_candidate;

  modport source (output valid, output distance, output row_index, output last_candidate,
                  input ready);
  modport sink (input valid, input distance, input row_index, input last_candidate,
                output ready);
endinterface

>>> design/knss_nbr_if.sv
interface knss_nbr_if;
  import knss_pkg::*;

  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  neighbour_index;
  logic [DIST_W-1:0] neighbour_distance;
  logic [RANK_W-1:0] rank;
  logic              last_of_run;

  modport source (output valid, output neighbour_index, output neighbour_distance,
                  output rank, output last_of_run, input ready);
  modport sink (input valid, input neighbour_index, input neighbour_distance,
                input rank, input last_of_run, output ready);
endinterface

>>> design/knss_cell.sv
module knss_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  knss_pkg::cell_ctrl_t ctrl,
  input  knss_pkg::entry_t    cand,
  input  knss_pkg::entry_t    left,
  input  knss_pkg::entry_t    right,
  input  logic                left_occ,
  input  logic                left_keep,
  output knss_pkg::entry_t    ent,
  output logic                occ,
  output logic                keep
);
  import knss_pkg::*;

  entry_t ent_next;

  always_comb begin
    occ  = ent.valid & en;
    // entries not larger than the candidate stay put (earlier arrival wins ties)
    keep = occ & (ent.distance <= cand.distance);
    ent_next = ent;
    if (ctrl.shift) begin
      ent_next = right;
    end else if (ctrl.insert) begin
      if (!keep) begin
        ent_next = left_keep ? cand : left;
      end
      ent_next.valid = en & (occ | left_occ);
    end
  end

  always_ff @(posedge clk) begin
    ent.distance <= ent_next.distance;
    ent.idx      <= ent_next.idx;
    if (rst) begin
      ent.valid <= 1'b0;
    end else begin
      ent.valid <= ent_next.valid;
    end
  end

endmodule

>>> design/k_nearest_stable_selection_core.sv
// Candidate intake: one transfer per cycle while collecting, inserted into the ranked chain at that clock edge.
// Last candidate: the sequencer enters its drain state and the head entry is registered and offered,
// then one result per cycle while the sink takes them; intake pauses while the chain drains.
// Candidates for a new query are not accepted until the chain has drained.
// Reset (rst, synchronous): empties the chain, drops any pending result, count register to 4.
`include "k_nearest_stable_selection_core_assert.svh"

module k_nearest_stable_selection_core #(
  parameter int K_MAX = 32
) (
  input  logic        clk,
  input  logic        rst,
  knss_cand_if.sink   cand,
  knss_nbr_if.source  nbr,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import knss_pkg::*;

  // Sequencer: collect candidates, or drain the chain out through the output register.
  localparam logic ST_COLLECT = 1'b0;
  localparam logic ST_DRAIN   = 1'b1;

  logic st;
  logic [CNT_W-1:0] neighbour_count;
  logic [KEFF_W-1:0] k_eff;

  // Chain wiring: index K_MAX is the empty slot past the tail.
  entry_t ents [0:K_MAX];
  logic   occs [0:K_MAX];
  logic   keeps[0:K_MAX];
  logic [K_MAX:0] valid_vec;
  logic [K_MAX-1:0] cell_en;
  entry_t cand_ent;
  cell_ctrl_t ctrl;

  logic in_fire;
  logic drain_step;

  logic              out_valid;
  logic [DIST_W-1:0] out_dist;
  logic [IDX_W-1:0]  out_idx;
  logic [RANK_W-1:0] out_rank;
  logic              out_last;
  logic [RANK_W-1:0] rank_cnt;

  // ---------------- configuration port ----------------
  logic reg_hit;
  assign reg_hit = (paddr[2] == REG_NEIGHBOUR_COUNT);
  assign pready  = 1'b1;
  assign prdata  = reg_hit ? {{(32-CNT_W){1'b0}}, neighbour_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbour_count <= COUNT_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      neighbour_count <= pwdata[CNT_W-1:0];
    end
  end

  // Effective k: zero acts as one, anything past the chain length acts as the full chain.
  always_comb begin
    k_eff = {{(KEFF_W-CNT_W){1'b0}}, neighbour_count};
    if (k_eff == '0) begin
      k_eff = KEFF_W'(1);
    end
    if (k_eff > KEFF_W'(K_MAX)) begin
      k_eff = KEFF_W'(K_MAX);
    end
  end

  // ---------------- handshakes ----------------
  assign cand.ready = (st == ST_COLLECT);
  assign in_fire    = cand.valid & cand.ready;
  // advance the drain when the output register is free or being emptied
  assign drain_step = (st == ST_DRAIN) & (~out_valid | nbr.ready);

  assign ctrl.insert = in_fire;
  assign ctrl.shift  = drain_step;

  assign cand_ent.valid    = 1'b1;
  assign cand_ent.distance = cand.distance;
  assign cand_ent.idx      = cand.row_index;

  // ---------------- chain of cells ----------------
  // Head of the chain sees an always-kept, always-occupied neighbor on its left,
  // so a candidate smaller than everything lands in cell 0.
  assign occs[0]  = 1'b1;
  assign keeps[0] = 1'b1;
  assign ents[K_MAX].valid    = 1'b0;
  assign ents[K_MAX].distance = '0;
  assign ents[K_MAX].idx      = '0;
  assign valid_vec[K_MAX]     = 1'b0;

  for (genvar g = 0; g < K_MAX; g++) begin : g_cell
    entry_t left_ent;
    entry_t own_ent;
    logic   own_occ;
    logic   own_keep;

    if (g == 0) begin : g_head
      assign left_ent = cand_ent;
    end else begin : g_body
      assign left_ent = ents[g-1];
    end

    assign cell_en[g] = (KEFF_W'(g) < k_eff);

    knss_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (cell_en[g]),
      .ctrl      (ctrl),
      .cand      (cand_ent),
      .left      (left_ent),
      .right     (ents[g+1]),
      .left_occ  (occs[g]),
      .left_keep (keeps[g]),
      .ent       (own_ent),
      .occ       (own_occ),
      .keep      (own_keep)
    );

    assign ents[g]      = own_ent;
    assign occs[g+1]    = own_occ;
    assign keeps[g+1]   = own_keep;
    assign valid_vec[g] = own_ent.valid;
  end

  // ---------------- sequencer and output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_COLLECT;
      rank_cnt  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (in_fire && cand.last_candidate) begin
        st <= ST_DRAIN;
      end
      if (drain_step) begin
        out_valid <= 1'b1;
        rank_cnt  <= rank_cnt + RANK_W'(1);
        // cell 1 empty means cell 0 holds the final entry: back to intake
        if (!valid_vec[1]) begin
          st       <= ST_COLLECT;
          rank_cnt <= '0;
        end
      end else if (nbr.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (drain_step) begin
      out_dist <= ents[0].distance;
      out_idx  <= ents[0].idx;
      out_rank <= rank_cnt;
      out_last <= ~valid_vec[1];
    end
  end

  assign nbr.valid              = out_valid;
  assign nbr.neighbour_index    = out_idx;
  assign nbr.neighbour_distance = out_dist;
  assign nbr.rank               = out_rank;
  assign nbr.last_of_run        = out_last;

  // ---------------- assertions ----------------
  // occupied cells always form a contiguous run from the head
  `KNSS_ASSERT_IMPL(a_prefix, clk, rst, 1'b1, $onehot(valid_vec + 1'b1))
  // the last candidate always leaves something to drain
  `KNSS_ASSERT_NEXT(a_last_drain, clk, rst, in_fire && cand.last_candidate, (st == ST_DRAIN) && valid_vec[0])
  // a drain step always presents a result
  `KNSS_ASSERT_NEXT(a_step_out, clk, rst, drain_step, nbr.valid)
  // while draining, the head cell holds an entry
  `KNSS_ASSERT_IMPL(a_drain_head, clk, rst, st == ST_DRAIN, valid_vec[0])

endmodule
